@@ design/hfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hfc_pkg;
    typedef enum logic [1:0] {
        CMD_F32_TO_F16  = 2'd0,
        CMD_F16_TO_F32  = 2'd1,
        CMD_BF16_TO_F32 = 2'd2,
        CMD_UNUSED      = 2'd3
    } cmd_t;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned CmdWidth  = 2;

    typedef struct packed {
        logic [CmdWidth-1:0]  command;
        logic [WordWidth-1:0] operand;
    } item_t;
endpackage
`default_nettype wire

@@ design/hfc_narrow.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hfc_narrow (
    input  wire logic [31:0] operand,
    output logic [15:0]      half
);
    import hfc_pkg::*;

    logic        sgn;
    logic [7:0]  bexp;
    logic [22:0] frac;
    logic signed [9:0] he;
    logic [23:0] sig;
    logic [4:0]  shamt;
    logic [23:0] shifted;
    logic [24:0] rnd_sub;
    logic [23:0] rnd_norm;
    logic [15:0] sub_res;
    logic [4:0]  he_inc;

    // field split and half exponent
    assign sgn  = operand[31];
    assign bexp = operand[30:23];
    assign frac = operand[22:0];
    assign he   = $signed({2'b00, bexp}) - 10'sd112;

    // subnormal path: shift first, then round at bit 13
    assign sig      = {1'b1, frac};
    assign shamt    = 5'(10'sd1 - he);
    assign shifted  = sig >> shamt;
    assign rnd_sub  = {1'b0, shifted} + 25'h0FFF + 25'(shifted[13]);
    assign sub_res  = {sgn, 15'(rnd_sub >> 13)};

    // normal path rounding
    assign rnd_norm = {1'b0, frac} + 24'h0FFF + 24'(frac[13]);
    assign he_inc   = he[4:0] + 5'd1;

    // select result
    always_comb
    begin
        if (bexp == 8'hff)
            half = {sgn, 5'h1f, (frac != 23'd0), 9'd0};
        else if (he >= 10'sd31)
            half = {sgn, 15'h7c00};
        else if (he <= 10'sd0)
        begin
            if (he < -10'sd10)
                half = {sgn, 15'd0};
            else
                half = sub_res;
        end
        else if (rnd_norm[23])
        begin
            if (he_inc == 5'h1f)
                half = {sgn, 15'h7c00};
            else
                half = {sgn, he_inc, 10'd0};
        end
        else
            half = {sgn, he[4:0], rnd_norm[22:13]};
    end
endmodule
`default_nettype wire

@@ design/hfc_widen.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hfc_widen (
    input  wire logic [15:0] half,
    output logic [31:0]      single
);
    import hfc_pkg::*;

    logic       sgn;
    logic [4:0] hexp;
    logic [9:0] frac;
    logic [3:0] lead;
    logic [9:0] nfrac;

    assign sgn  = half[15];
    assign hexp = half[14:10];
    assign frac = half[9:0];

    // normalizing shift of subnormal fraction (leading zero count plus one)
    always_comb
    begin
        lead = 4'd10;
        for (int i = 0; i < 10; i++)
            if (frac[i])
                lead = 4'(10 - i);
    end

    assign nfrac = 10'(frac << lead);

    always_comb
    begin
        if (hexp == 5'd0)
        begin
            if (frac == 10'd0)
                single = {sgn, 31'd0};
            else
                single = {sgn, 8'(8'd113 - {4'd0, lead}), nfrac, 13'd0};
        end
        else if (hexp == 5'h1f)
            single = {sgn, 8'hff, frac, 13'd0};
        else
            single = {sgn, 8'({3'd0, hexp} + 8'd112), frac, 13'd0};
    end
endmodule
`default_nettype wire

@@ design/half_float_conversion_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Converts one word per cycle between binary32, binary16 and bfloat16 bit
// patterns. Each beat is captured in an input register, converted by
// combinational logic and held in a result register, and a new beat is taken
// every cycle while the result side keeps up. Command 0 narrows binary32 to
// binary16 (round to nearest even, result in bits 15..0), command 1 widens
// binary16, command 2 widens bfloat16; command 3 returns zero.
module half_float_conversion_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // command [1:0], operand [33:2], zero [39:34]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata   // converted [31:0]
);
    import hfc_pkg::*;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        adv;
    logic [15:0] narrow_res;
    logic [31:0] widen_res;
    logic [31:0] conv_next;

    // pipeline advance
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.command <= s_tdata[1:0];
            in_item_reg.operand <= s_tdata[33:2];
        end
    end

    hfc_narrow u_narrow (
        .operand (in_item_reg.operand),
        .half    (narrow_res)
    );

    hfc_widen u_widen (
        .half   (in_item_reg.operand[15:0]),
        .single (widen_res)
    );

    // command select
    always_comb
    begin
        unique case (cmd_t'(in_item_reg.command))
            CMD_F32_TO_F16:  conv_next = {16'd0, narrow_res};
            CMD_F16_TO_F32:  conv_next = widen_res;
            CMD_BF16_TO_F32: conv_next = {in_item_reg.operand[15:0], 16'd0};
            default:         conv_next = 32'd0;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid_reg)
            out_data_reg <= conv_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule
`default_nettype wire

@@ sim/tb_half_float_conversion_core.sv @@
`timescale 1ns / 1ps
import hfc_pkg::*;

class conversion_scoreboard;
    logic [31:0] pending_words[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // expected word for one command and operand
    function logic [31:0] convert_word(cmd_t cmd, logic [31:0] opnd);
        logic [31:0] res;
        logic [15:0] h;
        logic        sg;
        int          bexp;
        int          he;
        int          lead;
        logic [31:0] frac;
        res = '0;
        case (cmd)
            CMD_F32_TO_F16:
            begin
                sg = opnd[31];
                bexp = int'(opnd[30:23]);
                frac = {9'd0, opnd[22:0]};
                he = bexp - 127 + 15;
                if (bexp == 255)
                    res = {16'd0, sg, 5'h1f, (frac != 0), 9'd0};
                else if (he >= 31)
                    res = {16'd0, sg, 15'h7c00};
                else if (he <= 0)
                begin
                    if (he < -10)
                        res = {16'd0, sg, 15'd0};
                    else
                    begin
                        frac = (frac | 32'h80_0000) >> (1 - he);
                        frac = frac + 32'h0fff + ((frac >> 13) & 32'd1);
                        res = {16'd0, ({sg, 15'd0} | frac[28:13])};
                    end
                end
                else
                begin
                    frac = frac + 32'h0fff + ((frac >> 13) & 32'd1);
                    if (frac[23])
                    begin
                        frac = 0;
                        he = he + 1;
                    end
                    if (he >= 31)
                        res = {16'd0, sg, 15'h7c00};
                    else
                        res = {16'd0, sg, he[4:0], frac[22:13]};
                end
            end
            CMD_F16_TO_F32:
            begin
                h = opnd[15:0];
                frac = {22'd0, h[9:0]};
                if (h[14:10] == 0)
                begin
                    if (frac == 0)
                        res = {h[15], 31'd0};
                    else
                    begin
                        lead = 0;
                        while (frac[10] == 0)
                        begin
                            frac = frac << 1;
                            lead++;
                        end
                        res = {h[15], 8'(113 - lead), frac[9:0], 13'd0};
                    end
                end
                else if (h[14:10] == 5'h1f)
                    res = {h[15], 8'hff, h[9:0], 13'd0};
                else
                    res = {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
            end
            CMD_BF16_TO_F32: res = {opnd[15:0], 16'd0};
            default: res = '0;
        endcase
        return res;
    endfunction

    function void note_input(logic [39:0] beat);
        pending_words.push_back(convert_word(cmd_t'(beat[1:0]), beat[33:2]));
    endfunction

    function void check_word(logic [31:0] got);
        logic [31:0] want;
        if (pending_words.size() == 0)
        begin
            report_error($sformatf("unexpected result %h", got));
            return;
        end
        want = pending_words.pop_front();
        if (got !== want)
            report_error($sformatf("converted got %h want %h", got, want));
    endfunction

    function void report_error(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endfunction
endclass

module tb_half_float_conversion_core;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    conversion_scoreboard board;
    bit   quiet;
    bit   hold_sink;
    longint cycles;

    half_float_conversion_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),  // command [1:0], operand [33:2], zero [39:34]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)   // converted [31:0]
    );

    // clock
    initial clk = 0;
    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // send one beat, with an optional random gap first
    task automatic send_beat(cmd_t cmd, logic [31:0] opnd);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, opnd, 2'(cmd)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input({6'd0, opnd, 2'(cmd)});
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge clk);
        while (board.pending_words.size() != 0)
            @(posedge clk);
    endtask

    // random float32 with weighted exponent to reach all narrowing paths
    function automatic logic [31:0] random_f32();
        logic [31:0] v;
        int k;
        v = $urandom();
        k = $urandom_range(0, 5);
        if (k == 0)
            v[30:23] = 8'($urandom_range(97, 113));
        else if (k == 1)
            v[30:23] = 8'($urandom_range(140, 143));
        else if (k == 2)
            v[30:23] = 8'($urandom_range(0, 1) ? 255 : 0);
        else if (k == 3)
            v[22:13] = 10'h3ff;
        return v;
    endfunction

    // receiver
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_word(m_tdata);
            if (hold_sink)
                m_tready <= 0;
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                // ready stays low over the burst, so no beat is taken here
                m_tready <= 0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                m_tready <= 1;
            end
            else
                m_tready <= 1;
        end
    end

    // long receiver hold-off, counted in its own process
    initial
    begin
        int n;
        hold_sink = 0;
        wait (cycles == 400);
        hold_sink = 1;
        for (n = 0; n < 60; n++)
            @(posedge clk);
        hold_sink = 0;
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        logic [31:0] directed[];
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
            32'hff80_0000, 32'h7fc0_0001, 32'hff80_0001, 32'h477f_f000, 32'h4780_0000,
            32'h3380_0000, 32'h3300_0000, 32'h3880_0000, 32'h387f_e000, 32'h3f80_1000,
            32'h3f80_3000, 32'h0000_0001, 32'hffff_ffff};
        board = new();
        quiet = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed corners
        foreach (directed[j])
            send_beat(CMD_F32_TO_F16, directed[j]);
        send_beat(CMD_F16_TO_F32, 32'hffff_0001);
        send_beat(CMD_F16_TO_F32, 32'h0000_83ff);
        send_beat(CMD_F16_TO_F32, 32'h0000_7c00);
        send_beat(CMD_F16_TO_F32, 32'h0000_fe01);
        send_beat(CMD_F16_TO_F32, 32'h0000_8000);
        send_beat(CMD_BF16_TO_F32, 32'hffff_ffff);
        send_beat(CMD_BF16_TO_F32, 32'h1234_0000);
        send_beat(CMD_UNUSED, 32'hffff_ffff);

        // sender pause until all results are in
        wait_drained();

        // random beats, no idling in the last part
        for (i = 0; i < 1200; i++)
        begin
            if (i == 1000)
                quiet = 1;
            case ($urandom_range(0, 9))
                0: send_beat(CMD_UNUSED, $urandom());
                1, 2: send_beat(CMD_F16_TO_F32, $urandom());
                3: send_beat(CMD_BF16_TO_F32, $urandom());
                default: send_beat(CMD_F32_TO_F16, random_f32());
            endcase
        end
        wait_drained();
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
